// ----- rtl/swst_pkg.sv -----
package swst_pkg;

    // Field widths
    localparam int ID_W     = 48;
    localparam int HANDLE_W = 16;

    // Default window depth (ids tracked)
    localparam int WINDOW_DEF = 16;

    // Largest id; the counter saturates here
    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    // Request codes
    typedef enum logic [1:0] {
        REQ_RESERVE_NEXT = 2'd0,
        REQ_RESERVE_ID   = 2'd1,
        REQ_MARK         = 2'd2,
        REQ_QUERY        = 2'd3
    } req_type_t;

    // Command beat
    typedef struct packed {
        req_type_t             req_type;
        logic [ID_W-1:0]       msg_id;
        logic                  follow_mode;
        logic [HANDLE_W-1:0]   header_handle;
    } swst_cmd_t;

    // Result beat
    typedef struct packed {
        logic                  success;
        logic                  can_retry;
        logic                  evicted_valid;
        logic [HANDLE_W-1:0]   evicted_handle;
        logic [ID_W-1:0]       result_id;
        logic                  is_available;
        logic                  will_be_available;
        logic [ID_W-1:0]       window_begin;
        logic [ID_W-1:0]       window_end;
        logic [ID_W-1:0]       next_id;
        logic [HANDLE_W-1:0]   stored_handle;
    } swst_rsp_t;

endpackage

// ----- rtl/sliding_window_slot_tracker_core.sv -----
// Pipeline: an accepted command passes the input register, then the result
// register, and its result comes out with done high for one cycle.
// Throughput: one command per cycle; busy stays low, start is always taken.
// The receiver cannot stall; each result beat is shown for one cycle only.
// Reset (async, rst_n low) clears the id counter, presence bitmap, slot
// pointer and pipeline valids; the slot handle store is not cleared.
module sliding_window_slot_tracker_core #(
    parameter int WINDOW = swst_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  swst_pkg::swst_cmd_t cmd,
    output logic                done,
    output swst_pkg::swst_rsp_t result
);

    localparam int ID_W     = swst_pkg::ID_W;
    localparam int HANDLE_W = swst_pkg::HANDLE_W;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);

    // Input stage
    swst_pkg::swst_cmd_t cmd_reg;
    logic                item_valid_reg;
    logic [SLOT_W-1:0]   slot_id_reg;
    logic [SLOT_W-1:0]   slot_id;
    logic                accept;

    // Tracker state
    logic [ID_W-1:0]     cnt_reg,      cnt_next;
    logic [WINDOW-1:0]   pres_reg,     pres_next;
    logic [SLOT_W-1:0]   cnt_slot_reg, cnt_slot_next;

    // Handle store
    logic [HANDLE_W-1:0] handle_mem [WINDOW];
    logic [HANDLE_W-1:0] rd_reg;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;

    // Result stage
    swst_pkg::swst_rsp_t res_reg,       res_next;
    logic                sel_evict_reg, sel_evict_next;
    logic                sel_query_reg, sel_query_next;
    logic                done_reg;

    // Window decode
    logic [ID_W-1:0]     id;
    logic [ID_W-1:0]     last;
    logic [ID_W-1:0]     offset;
    logic [SLOT_W-1:0]   off_idx;
    logic [WINDOW-1:0]   set_mask;
    logic                lt, gt, eq, in_win, too_old, at_max, pbit, adv;
    logic [CNT_W-1:0]    lz, tz;
    logic [ID_W-1:0]     win_begin, win_end, newest, pick;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    swst_slot_mod #(
        .WINDOW (WINDOW)
    ) u_slot_mod (
        .id   (cmd.msg_id),
        .slot (slot_id)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd;
            slot_id_reg <= slot_id;
        end
    end

    // Compares against the counter
    assign id      = cmd_reg.msg_id;
    assign last    = cnt_reg;
    assign lt      = id < last;
    assign gt      = id > last;
    assign eq      = id == last;
    assign offset  = last - ID_W'(1) - id;
    assign in_win  = lt && (offset < ID_W'(WINDOW));
    assign too_old = lt && !in_win;
    assign at_max  = last == swst_pkg::ID_MAX;
    assign off_idx = offset[SLOT_W-1:0];
    assign pbit    = in_win && pres_reg[off_idx];
    assign set_mask = WINDOW'(1) << off_idx;

    // Leading and trailing zero counts of the bitmap
    always_comb
    begin
        lz = CNT_W'(WINDOW);
        for (int i = 0; i < WINDOW; i++)
        begin
            if (pres_reg[i])
                lz = CNT_W'(WINDOW - 1 - i);
        end
    end

    always_comb
    begin
        tz = CNT_W'(WINDOW);
        for (int i = WINDOW - 1; i >= 0; i--)
        begin
            if (pres_reg[i])
                tz = CNT_W'(i);
        end
    end

    // Query window bounds and next-id pick
    always_comb
    begin
        win_begin = (last < ID_W'(WINDOW)) ? '0
                                           : last - ID_W'(WINDOW) + ID_W'(lz);
        win_end   = (ID_W'(tz) > last) ? '0 : last - ID_W'(tz);
        newest    = (last == '0) ? '0 : last - ID_W'(1);
        pick      = id;
        if (!cmd_reg.follow_mode)
        begin
            if (newest >= id)
                pick = newest;
        end
        else
        begin
            if (id < win_begin)
                pick = win_begin;
        end
    end

    // Request decode and state update
    always_comb
    begin
        res_next           = '0;
        res_next.result_id = id;
        sel_evict_next     = 1'b0;
        sel_query_next     = 1'b0;
        cnt_next           = cnt_reg;
        pres_next          = pres_reg;
        cnt_slot_next      = cnt_slot_reg;
        wr_en              = 1'b0;
        wr_addr            = cnt_slot_reg;
        adv                = 1'b0;

        if (item_valid_reg)
        begin
            unique case (cmd_reg.req_type)
                swst_pkg::REQ_RESERVE_NEXT:
                begin
                    if (at_max)
                        res_next.result_id = last;
                    else
                        adv = 1'b1;
                end
                swst_pkg::REQ_RESERVE_ID:
                begin
                    if (too_old)
                        res_next.can_retry = 1'b0;
                    else if (gt)
                        res_next.can_retry = 1'b1;
                    else if (eq)
                        adv = !at_max;
                    else if (!pbit)
                    begin
                        pres_next        = pres_reg | set_mask;
                        wr_en            = 1'b1;
                        wr_addr          = slot_id_reg;
                        res_next.success = 1'b1;
                    end
                end
                swst_pkg::REQ_MARK:
                begin
                    if (in_win)
                    begin
                        pres_next        = pres_reg | set_mask;
                        res_next.success = 1'b1;
                    end
                end
                swst_pkg::REQ_QUERY:
                begin
                    sel_query_next             = 1'b1;
                    res_next.is_available      = pbit;
                    res_next.will_be_available = !lt || in_win;
                    res_next.window_begin      = win_begin;
                    res_next.window_end        = win_end;
                    res_next.next_id           = pick;
                end
            endcase

            // One-step advance: evict oldest slot, reuse it for the new id
            if (adv)
            begin
                res_next.success       = 1'b1;
                res_next.can_retry     = 1'b1;
                res_next.evicted_valid = pres_reg[WINDOW-1];
                res_next.result_id     = last;
                sel_evict_next         = pres_reg[WINDOW-1];
                wr_en                  = 1'b1;
                wr_addr                = cnt_slot_reg;
                pres_next              = {pres_reg[WINDOW-2:0], 1'b0};
                cnt_next               = last + ID_W'(1);
                cnt_slot_next          = (cnt_slot_reg == SLOT_W'(WINDOW - 1))
                                         ? '0 : cnt_slot_reg + SLOT_W'(1);
            end
        end
    end

    // Handle store: read-first, one read and at most one write per beat
    assign rd_addr = (cmd_reg.req_type == swst_pkg::REQ_QUERY) ? slot_id_reg
                                                                : cnt_slot_reg;

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            if (wr_en)
                handle_mem[wr_addr] <= cmd_reg.header_handle;
            rd_reg <= handle_mem[rd_addr];
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pres_reg     <= '0;
            cnt_slot_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            pres_reg     <= pres_next;
            cnt_slot_reg <= cnt_slot_next;
            done_reg     <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            res_reg       <= res_next;
            sel_evict_reg <= sel_evict_next;
            sel_query_reg <= sel_query_next;
        end
    end

    // Result beat: handles come straight from the store read register
    always_comb
    begin
        result                = res_reg;
        result.evicted_handle = sel_evict_reg ? rd_reg : '0;
        result.stored_handle  = sel_query_reg ? rd_reg : '0;
    end

    assign done = done_reg;

    // Counter only ever steps by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != $past(cnt_reg) |-> cnt_reg == $past(cnt_reg) + ID_W'(1))
        else $error("id counter moved by more than one");

    // Every accepted command yields a result beat through the input and result registers
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("missing result beat");

    // An eviction only comes with a successful advance
    a_evict_adv: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.evicted_valid |-> result.success && result.can_retry)
        else $error("eviction without advance");

endmodule

// ----- rtl/swst_slot_mod.sv -----
// Ring slot of an id: id modulo WINDOW.
// Each id nibble is weighted by 16^k mod WINDOW, reduced through a constant
// residue table, the partial residues summed, and the sum reduced once more.
module swst_slot_mod #(
    parameter int WINDOW = swst_pkg::WINDOW_DEF,
    localparam int SLOT_W = $clog2(WINDOW)
) (
    input  logic [swst_pkg::ID_W-1:0] id,
    output logic [SLOT_W-1:0]         slot
);

    localparam int NIBBLES = swst_pkg::ID_W / 4;

    logic [SLOT_W-1:0] mod_tbl [256];
    logic [3:0]        nib_wt  [NIBBLES];
    logic [SLOT_W-1:0] part    [NIBBLES];
    logic [7:0]        part_sum;

    // Residue table: v mod WINDOW for any 8-bit v
    for (genvar v = 0; v < 256; v++) begin : g_tbl
        localparam int RES = v % WINDOW;
        assign mod_tbl[v] = SLOT_W'(RES);
    end

    // Nibble weights: 16^k mod WINDOW; nibble times weight needs 8 bits
    for (genvar k = 0; k < NIBBLES; k++) begin : g_wt
        localparam longint unsigned WT = (64'd1 << (4 * k)) % WINDOW;
        assign nib_wt[k] = 4'(WT);
        assign part[k]   = mod_tbl[8'(id[4*k +: 4]) * 8'(nib_wt[k])];
    end

    // Sum of partial residues, at most NIBBLES * (WINDOW-1)
    always_comb
    begin
        part_sum = '0;
        for (int k = 0; k < NIBBLES; k++)
        begin
            part_sum = part_sum + 8'(part[k]);
        end
    end

    assign slot = mod_tbl[part_sum];

endmodule
